/* rtl/pnq_pkg.sv */
// ----------------------------------------------------------------------------
// pnq_pkg - shared types and constants
// Widths, status codes and default sizes for the peak normalising quantiser.
// ----------------------------------------------------------------------------
package pnq_pkg;

  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_STORE_DEPTH  = 16384;

  localparam int SAMPLE_W = 32;
  localparam int PEAK_W   = 31;
  localparam int CODE_W   = 16;
  localparam int Q_W      = 15;
  localparam int CFG_W    = 5;

  localparam logic [Q_W-1:0]    FULL_SCALE = 15'd32767;
  localparam logic [PEAK_W-1:0] PEAK_MAX   = 31'h7FFF_FFFF;
  localparam logic [PEAK_W-1:0] PEAK_INIT  = 31'd1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BUSY  = 2'd3
  } status_t;

endpackage

/* rtl/pnq_div.sv */
// ----------------------------------------------------------------------------
// pnq_div - scaled restoring divider
// Returns min(mag*32767/peak, 32767), truncated, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pnq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pnq_pkg::SAMPLE_W-1:0] mag,
  input  logic [pnq_pkg::PEAK_W-1:0]   peak,
  output logic                        done,
  output logic [pnq_pkg::Q_W-1:0]      quot
);
  import pnq_pkg::*;

  localparam int N_W = SAMPLE_W + Q_W;

  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_CMP  = 4'b0100,
    D_ITER = 4'b1000
  } dstate_t;

  dstate_t              state;
  logic [SAMPLE_W-1:0]  mag_q;
  logic [PEAK_W-1:0]    div_q;
  logic [N_W-1:0]       prod;
  logic [PEAK_W-1:0]    rem;
  logic [Q_W-1:0]       low;
  logic [3:0]           iter;

  logic [PEAK_W:0]      trial;
  logic [PEAK_W:0]      diff;
  logic                 ge;

  assign trial = {rem, low[Q_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            mag_q <= mag;
            div_q <= peak;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          // mag * 32767 as a shift and subtract
          prod  <= {mag_q, {Q_W{1'b0}}} - {{Q_W{1'b0}}, mag_q};
          state <= D_CMP;
        end
        D_CMP: begin
          if (prod >= {1'b0, div_q, {Q_W{1'b0}}}) begin
            quot  <= FULL_SCALE;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            rem   <= prod[N_W-2:Q_W];
            low   <= prod[Q_W-1:0];
            iter  <= 4'(Q_W - 1);
            state <= D_ITER;
          end
        end
        D_ITER: begin
          rem  <= ge ? diff[PEAK_W-1:0] : trial[PEAK_W-1:0];
          low  <= {low[Q_W-2:0], 1'b0};
          quot <= {quot[Q_W-2:0], ge};
          if (iter == 4'd0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            iter <= iter - 4'd1;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* rtl/peak_normalizing_int16_quantizer_core.sv */
// ----------------------------------------------------------------------------
// peak_normalizing_int16_quantizer_core - per-channel peak normalisation
// Stores interleaved microvolt samples and reads them back as int16 codes.
// ----------------------------------------------------------------------------
// Usage: load beats (opcode 0) append a signed microvolt sample to the sample
// store and raise the peak of its channel; channels rotate through
// num_channels. Fetch beats (opcode 1) return the stored samples in load order
// as trunc(v*32767/peak), clamped to +-32767, with the channel and its peak
// (step size peak/32767 uV). The last fetch flags last and clears counts and
// peaks. A load goes through a peak table read, the update and the result. A
// fetch goes through the store and peak read, then the shared radix-2 divider
// (multiply, range check, 15 quotient bits), then the result; a clamped code
// leaves the divider after its range check. An empty fetch goes straight to
// the result. One beat is in flight at a time; the output register lets the
// next beat in while a result waits. Peaks live in a small synchronous RAM
// whose entries read as 1 until written after reset or a final fetch.
// ----------------------------------------------------------------------------
module peak_normalizing_int16_quantizer_core #(
  parameter int MAX_CHANNELS = pnq_pkg::DEF_MAX_CHANNELS,
  parameter int STORE_DEPTH  = pnq_pkg::DEF_STORE_DEPTH,
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [pnq_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          opcode,
  input  logic signed [pnq_pkg::SAMPLE_W-1:0] sample_microvolts,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [1:0]                    status,
  output logic signed [pnq_pkg::CODE_W-1:0] code,
  output logic [CH_W-1:0]               channel,
  output logic [pnq_pkg::PEAK_W-1:0]    channel_peak,
  output logic                          last
);
  import pnq_pkg::*;

  localparam int CC_W  = ($clog2(MAX_CHANNELS + 1) > CFG_W) ? $clog2(MAX_CHANNELS + 1) : CFG_W;
  localparam int IDX_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LCHK  = 5'b00010,
    S_FMAG  = 5'b00100,
    S_FWAIT = 5'b01000,
    S_PUT   = 5'b10000
  } state_t;

  state_t                state;
  logic [CFG_W-1:0]      num_channels;
  logic [CNT_W-1:0]      stored_count;
  logic [CNT_W-1:0]      read_position;
  logic [CH_W-1:0]       load_channel;
  logic [CH_W-1:0]       read_channel;
  logic [MAX_CHANNELS-1:0] pk_vld;

  // captured beat and working values
  logic [SAMPLE_W-1:0]   smp;
  logic [CH_W-1:0]       act_ch;
  logic                  neg;
  logic [PEAK_W-1:0]     pk_use;

  // pending result
  status_t               res_status;
  logic [CODE_W-1:0]     res_code;
  logic [CH_W-1:0]       res_ch;
  logic [PEAK_W-1:0]     res_pk;
  logic                  res_last;

  // memories
  logic [SAMPLE_W-1:0]   store_mem [STORE_DEPTH];
  logic [PEAK_W-1:0]     peak_mem  [MAX_CHANNELS];
  logic                  st_we, st_re;
  logic [IDX_W-1:0]      st_waddr, st_raddr;
  logic [SAMPLE_W-1:0]   st_rdata;
  logic                  pk_we, pk_re;
  logic [CH_W-1:0]       pk_waddr, pk_raddr;
  logic [PEAK_W-1:0]     pk_wdata, pk_rdata;

  // divider
  logic                  div_start, div_done;
  logic [SAMPLE_W-1:0]   div_mag;
  logic [Q_W-1:0]        div_q;

  logic [CC_W-1:0]       chan_cnt;
  logic [CC_W-1:0]       ncw;
  logic                  accept;
  logic                  empty;
  logic [PEAK_W-1:0]     pk_cur;
  logic [SAMPLE_W-1:0]   lmag;
  logic [PEAK_W-1:0]     lmag_sat;
  logic [PEAK_W-1:0]     new_pk;
  logic                  load_ok;
  status_t               load_status;
  logic [CNT_W-1:0]      rp_inc;
  logic [CODE_W-1:0]     q_ext;

  // effective channel count: 0 acts as 1, above MAX_CHANNELS clamps
  assign ncw = CC_W'(num_channels);
  always_comb begin
    priority if (ncw == '0)                        chan_cnt = CC_W'(1);
    else if (ncw > CC_W'(MAX_CHANNELS))            chan_cnt = CC_W'(MAX_CHANNELS);
    else                                           chan_cnt = ncw;
  end

  function automatic logic [CH_W-1:0] chan_now(input logic [CH_W-1:0] ctr,
                                               input logic [CC_W-1:0] cnt);
    return (CC_W'(ctr) < cnt) ? ctr : '0;
  endfunction

  function automatic logic [CH_W-1:0] chan_next(input logic [CH_W-1:0] ctr,
                                                input logic [CC_W-1:0] cnt);
    logic [CC_W-1:0] c;
    c = CC_W'(chan_now(ctr, cnt)) + CC_W'(1);
    return (c >= cnt) ? '0 : c[CH_W-1:0];
  endfunction

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign empty      = (stored_count == '0) || (read_position >= stored_count);

  // peak read: an entry not written since the last clear reads as one
  assign pk_cur = pk_vld[act_ch] ? pk_rdata : PEAK_INIT;

  // load magnitude, most negative value saturates
  assign lmag     = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
  assign lmag_sat = lmag[SAMPLE_W-1] ? PEAK_MAX : lmag[PEAK_W-1:0];
  assign new_pk   = (lmag_sat > pk_cur) ? lmag_sat : pk_cur;

  always_comb begin
    priority if (read_position != '0)                  load_status = ST_BUSY;
    else if (stored_count >= CNT_W'(STORE_DEPTH))      load_status = ST_FULL;
    else                                               load_status = ST_OK;
  end
  assign load_ok = (load_status == ST_OK);

  assign div_mag = st_rdata[SAMPLE_W-1] ? (~st_rdata + 1'b1) : st_rdata;
  assign rp_inc  = read_position + CNT_W'(1);
  assign q_ext   = {1'b0, div_q};

  // memory port control
  always_comb begin
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = stored_count[IDX_W-1:0];
    st_raddr  = read_position[IDX_W-1:0];
    pk_we     = 1'b0;
    pk_re     = 1'b0;
    pk_waddr  = act_ch;
    pk_raddr  = chan_now(load_channel, chan_cnt);
    pk_wdata  = new_pk;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!opcode) begin
            pk_re = 1'b1;
          end else if (!empty) begin
            st_re    = 1'b1;
            pk_re    = 1'b1;
            pk_raddr = chan_now(read_channel, chan_cnt);
          end
        end
      end
      S_LCHK: begin
        st_we = load_ok;
        pk_we = load_ok;
      end
      S_FMAG: div_start = 1'b1;
      S_FWAIT, S_PUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store_mem[st_waddr] <= smp;
    if (st_re) st_rdata <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (pk_we) peak_mem[pk_waddr] <= pk_wdata;
    if (pk_re) pk_rdata <= peak_mem[pk_raddr];
  end

  // divider takes the peak straight from the table read as it starts
  pnq_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .mag   (div_mag),
    .peak  (pk_cur),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= CFG_W'(1);
    end else if (cfg_wen) begin
      num_channels <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stored_count  <= '0;
      read_position <= '0;
      load_channel  <= '0;
      read_channel  <= '0;
      pk_vld        <= '0;
      result_valid  <= 1'b0;
    end else begin
      // a pending result moves out as soon as the output register is free
      if (state == S_PUT && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            smp <= sample_microvolts;
            if (!opcode) begin
              act_ch <= chan_now(load_channel, chan_cnt);
              state  <= S_LCHK;
            end else if (empty) begin
              res_status <= ST_EMPTY;
              res_code   <= '0;
              res_ch     <= '0;
              res_pk     <= PEAK_INIT;
              res_last   <= 1'b0;
              state      <= S_PUT;
            end else begin
              act_ch <= chan_now(read_channel, chan_cnt);
              state  <= S_FMAG;
            end
          end
        end
        S_LCHK: begin
          res_status <= load_status;
          res_code   <= '0;
          res_ch     <= act_ch;
          res_last   <= 1'b0;
          if (load_ok) begin
            res_pk         <= new_pk;
            pk_vld[act_ch] <= 1'b1;
            stored_count   <= stored_count + CNT_W'(1);
            load_channel   <= chan_next(load_channel, chan_cnt);
          end else begin
            res_pk <= pk_cur;
          end
          state <= S_PUT;
        end
        S_FMAG: begin
          neg    <= st_rdata[SAMPLE_W-1];
          pk_use <= pk_cur;
          state  <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            res_status <= ST_OK;
            res_code   <= neg ? (~q_ext + 1'b1) : q_ext;
            res_ch     <= act_ch;
            res_pk     <= pk_use;
            if (rp_inc >= stored_count) begin
              // final sample of the set: back to an empty store
              res_last      <= 1'b1;
              stored_count  <= '0;
              read_position <= '0;
              load_channel  <= '0;
              read_channel  <= '0;
              pk_vld        <= '0;
            end else begin
              res_last      <= 1'b0;
              read_position <= rp_inc;
              read_channel  <= chan_next(read_channel, chan_cnt);
            end
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (!result_valid || result_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register, loaded as the pending result moves across
  always_ff @(posedge clk) begin
    if (state == S_PUT && (!result_valid || result_ready)) begin
      status       <= res_status;
      code         <= res_code;
      channel      <= res_ch;
      channel_peak <= res_pk;
      last         <= res_last;
    end
  end

endmodule

/* bench/peak_normalizing_int16_quantizer_core_tb.sv */
// ----------------------------------------------------------------------------
// peak_normalizing_int16_quantizer_core_tb - self-checking bench
// Drives load and fetch beats into the quantiser under random back-pressure.
// A behavioural predictor tracks the sample store, channel peaks and read-out
// position, and every result beat is compared with the oldest prediction.
// A scripted opening covers the edge cases; random phases sweep the channel
// setting; a closing set is loaded and read back with no idling.
// ----------------------------------------------------------------------------
module peak_normalizing_int16_quantizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pnq_pkg::*;

  localparam int MAX_CH      = DEF_MAX_CHANNELS;
  localparam int DEPTH       = DEF_STORE_DEPTH;
  localparam int CH_W        = $clog2(MAX_CH);
  localparam int RANDOM_BEATS = 1050;
  localparam int CLOSING_LOADS = 64;
  // About 1300 beats in all; the limit leaves a wide margin.
  localparam longint CYCLE_LIMIT = 1_000_000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    status_t                  status;
    logic signed [CODE_W-1:0] code;
    logic [CH_W-1:0]          channel;
    logic [PEAK_W-1:0]        peak;
    logic                     last;
  } quant_res_t;

  typedef enum logic [1:0] {
    ROW_CFG,    // write num_channels with smp[4:0]
    ROW_BEAT,   // beat checked against the predictor
    ROW_TYPED   // beat checked against the result typed in the row
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        op;
    logic [31:0] smp;
    quant_res_t  want;
  } stim_row_t;

  localparam int SCRIPT_ROWS = 30;

  // Opening script. Typed results are the obvious ones: empty fetches,
  // full-scale and most-negative samples, refused loads, simple ratios.
  stim_row_t script [SCRIPT_ROWS] = '{
    '{ROW_CFG,   OP_LOAD,  32'd1,          '0},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_EMPTY, 16'sd0, 4'd0, 31'd1, 1'b0}},
    '{ROW_TYPED, OP_LOAD,  32'd0,          '{ST_OK, 16'sd0, 4'd0, 31'd1, 1'b0}},
    // most negative sample: magnitude saturates the peak
    '{ROW_TYPED, OP_LOAD,  32'h8000_0000,  '{ST_OK, 16'sd0, 4'd0, PEAK_MAX, 1'b0}},
    '{ROW_TYPED, OP_LOAD,  32'h7FFF_FFFF,  '{ST_OK, 16'sd0, 4'd0, PEAK_MAX, 1'b0}},
    '{ROW_TYPED, OP_LOAD,  32'hFFFF_FFFF,  '{ST_OK, 16'sd0, 4'd0, PEAK_MAX, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'hFFFF_FFFF,  '{ST_OK, 16'sd0, 4'd0, PEAK_MAX, 1'b0}},
    // load once read-out has started is refused
    '{ROW_TYPED, OP_LOAD,  32'd5,          '{ST_BUSY, 16'sd0, 4'd0, PEAK_MAX, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_OK, -16'sd32767, 4'd0, PEAK_MAX, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_OK, 16'sd32767, 4'd0, PEAK_MAX, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_OK, 16'sd0, 4'd0, PEAK_MAX, 1'b1}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_EMPTY, 16'sd0, 4'd0, 31'd1, 1'b0}},
    // peaks were cleared by the last fetch
    '{ROW_TYPED, OP_LOAD,  32'd100,        '{ST_OK, 16'sd0, 4'd0, 31'd100, 1'b0}},
    '{ROW_TYPED, OP_LOAD,  -32'sd50,       '{ST_OK, 16'sd0, 4'd0, 31'd100, 1'b0}},
    '{ROW_TYPED, OP_LOAD,  32'd7,          '{ST_OK, 16'sd0, 4'd0, 31'd100, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_OK, 16'sd32767, 4'd0, 31'd100, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_OK, -16'sd16383, 4'd0, 31'd100, 1'b0}},
    '{ROW_TYPED, OP_FETCH, 32'd0,          '{ST_OK, 16'sd2293, 4'd0, 31'd100, 1'b1}},
    '{ROW_CFG,   OP_LOAD,  32'd4,          '0},
    '{ROW_BEAT,  OP_LOAD,  32'd1000,       '0},
    '{ROW_BEAT,  OP_LOAD,  -32'sd2000000,  '0},
    '{ROW_BEAT,  OP_LOAD,  32'd30000,      '0},
    // load counter sits at 3, beyond the new count of 2: falls back to 0
    '{ROW_CFG,   OP_LOAD,  32'd2,          '0},
    '{ROW_BEAT,  OP_LOAD,  32'd77,         '0},
    '{ROW_CFG,   OP_LOAD,  32'd4,          '0},
    '{ROW_BEAT,  OP_FETCH, 32'd0,          '0},
    // read counter at 1 with one channel: channel 0, the first two codes clamp to full scale
    '{ROW_CFG,   OP_LOAD,  32'd1,          '0},
    '{ROW_BEAT,  OP_FETCH, 32'd0,          '0},
    '{ROW_BEAT,  OP_FETCH, 32'd0,          '0},
    '{ROW_BEAT,  OP_FETCH, 32'd0,          '0}
  };

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wen = 1'b0;
  logic [CFG_W-1:0]           cfg_wdata = '0;
  logic                       item_valid = 1'b0;
  logic                       item_ready;
  logic                       opcode = OP_LOAD;
  logic signed [SAMPLE_W-1:0] sample_microvolts = '0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic [1:0]                 status;
  logic signed [CODE_W-1:0]   code;
  logic [CH_W-1:0]            channel;
  logic [PEAK_W-1:0]          channel_peak;
  logic                       last;

  always #4 clk = ~clk;

  peak_normalizing_int16_quantizer_core #(
    .MAX_CHANNELS (MAX_CH),
    .STORE_DEPTH  (DEPTH)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .opcode            (opcode),
    .sample_microvolts (sample_microvolts),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .status            (status),
    .code              (code),
    .channel           (channel),
    .channel_peak      (channel_peak),
    .last              (last)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a shadow of the sample store and channel bookkeeping
  // --------------------------------------------------------------------------
  logic [31:0]       samples_held [DEPTH];
  logic [PEAK_W-1:0] peak_uv [MAX_CH];
  int unsigned       held_count  = 0;
  int unsigned       readout_pos = 0;
  int unsigned       load_ctr    = 0;
  int unsigned       read_ctr    = 0;
  logic [CFG_W-1:0]  chan_setting = 5'd1;

  quant_res_t due_results [$];   // predicted result beats, oldest first

  // bench bookkeeping
  int unsigned tx_gap_pct   = 0;   // chance of an idle burst before a load/fetch beat
  int unsigned rx_stall_pct = 0;   // chance of a stall burst on the result side
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;
  int unsigned loads_sent   = 0;
  int unsigned fetches_sent = 0;
  int unsigned random_beats = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned full_scale_codes = 0;
  logic [31:0] settings_used = '0;
  longint      cycle_count;

  initial begin
    for (int i = 0; i < MAX_CH; i++) peak_uv[i] = PEAK_INIT;
  end

  // register value 0 behaves as 1, anything above the table size as the table size
  function automatic int unsigned eff_channels();
    if (chan_setting == 0) return 1;
    if (chan_setting > MAX_CH) return MAX_CH;
    return chan_setting;
  endfunction

  // a counter left beyond a lowered channel count reads as channel 0
  function automatic int unsigned ctr_channel(input int unsigned ctr);
    return (ctr < eff_channels()) ? ctr : 0;
  endfunction

  function automatic int unsigned ctr_advance(input int unsigned ctr);
    int unsigned nxt;
    nxt = ctr_channel(ctr) + 1;
    return (nxt >= eff_channels()) ? 0 : nxt;
  endfunction

  // Works out the result of one accepted beat and advances the shadow state.
  task automatic quantise_beat(input logic op, input logic [31:0] smp,
                               output quant_res_t r);
    int unsigned ch;
    longint      v;
    longint      mag;
    longint      q;
    r = '{ST_OK, 16'sd0, '0, PEAK_INIT, 1'b0};
    if (op == OP_LOAD) begin
      ch = ctr_channel(load_ctr);
      r.channel = CH_W'(ch);
      r.peak = peak_uv[ch];
      if (readout_pos != 0) begin
        r.status = ST_BUSY;
      end else if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        samples_held[held_count] = smp;
        held_count++;
        v = longint'($signed(smp));
        mag = (v < 0) ? -v : v;
        if (mag > longint'(PEAK_MAX)) mag = longint'(PEAK_MAX);
        if (mag > longint'(peak_uv[ch])) peak_uv[ch] = PEAK_W'(mag);
        r.peak = peak_uv[ch];
        load_ctr = ctr_advance(load_ctr);
      end
    end else if (held_count == 0 || readout_pos >= held_count) begin
      r.status = ST_EMPTY;
    end else begin
      ch = ctr_channel(read_ctr);
      v = longint'($signed(samples_held[readout_pos]));
      mag = (v < 0) ? -v : v;
      q = (mag * 32767) / longint'(peak_uv[ch]);
      if (q > 32767) q = 32767;
      r.code = (v < 0) ? -CODE_W'(q) : CODE_W'(q);
      r.channel = CH_W'(ch);
      r.peak = peak_uv[ch];
      readout_pos++;
      read_ctr = ctr_advance(read_ctr);
      r.last = (readout_pos >= held_count);
      if (r.last) begin
        held_count = 0;
        readout_pos = 0;
        load_ctr = 0;
        read_ctr = 0;
        for (int i = 0; i < MAX_CH; i++) peak_uv[i] = PEAK_INIT;
      end
    end
  endtask

  // Mixed magnitudes: full range, small values near zero, shifted spreads
  // and the extremes.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 2000)) - 32'd1000;
      2: return 32'($signed($urandom()) >>> $urandom_range(1, 31));
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'd1;
          default: return 32'd0;
        endcase
      end
      default: return 32'($signed($urandom()) >>> $urandom_range(8, 24));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("MISMATCH result %0d: %s got %0h expected %0h",
               results_seen, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after the
  // beat is taken. Valid is only dropped for an idle burst or a drain, never in the
  // same step it is raised.
  // --------------------------------------------------------------------------
  task automatic issue(input logic op, input logic [31:0] smp,
                       input bit given, input quant_res_t preset);
    quant_res_t pred;
    if (tx_gap_pct != 0 && $urandom_range(1, 100) <= tx_gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    item_valid <= 1'b1;
    opcode <= op;
    sample_microvolts <= smp;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    quantise_beat(op, smp, pred);
    due_results.push_back(given ? preset : pred);
    if (op == OP_LOAD) loads_sent++;
    else fetches_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // the register is only touched with the block idle
  task automatic write_num_channels(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    chan_setting = value;
    settings_used[value] = 1'b1;
    @(negedge clk);
  endtask

  // One random phase: mostly whole load-then-fetch sets with random content.
  // Now and then a stray fetch opens read-out early, a load lands mid
  // read-out, a fetch finds nothing, or the set is left half read so the
  // next channel setting applies to it.
  task automatic run_phase(input int unsigned budget);
    int unsigned sent;
    int unsigned nload;
    bit          cut;
    sent = 0;
    while (sent < budget) begin
      nload = (readout_pos != 0) ? 0 : $urandom_range(1, 40);
      repeat (nload) begin
        if ($urandom_range(0, 49) == 0) issue(OP_FETCH, rand_sample(), 1'b0, '0);
        else issue(OP_LOAD, rand_sample(), 1'b0, '0);
        sent++;
      end
      cut = ($urandom_range(0, 4) == 0);
      while (held_count != 0 && !(cut && $urandom_range(0, 7) == 0)) begin
        if ($urandom_range(0, 19) == 0) issue(OP_LOAD, rand_sample(), 1'b0, '0);
        else issue(OP_FETCH, rand_sample(), 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        issue(OP_FETCH, rand_sample(), 1'b0, '0);
        sent++;
      end
    end
    random_beats += sent;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: result_ready stalls in bursts of random length, counted in clock cycles
  // --------------------------------------------------------------------------
  always begin
    @(negedge clk);
    if (rx_stall_pct != 0 && $urandom_range(1, 100) <= rx_stall_pct) begin
      result_ready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    result_ready <= 1'b1;
  end

  // Result checker: each taken result beat against the oldest prediction
  always @(posedge clk) begin : check_results
    quant_res_t want;
    if (!rst && result_valid && result_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result beat", {62'd0, status}, '0);
      end else begin
        want = due_results.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (code !== want.code) report_mismatch("code", code, want.code);
        if (channel !== want.channel) report_mismatch("channel", channel, want.channel);
        if (channel_peak !== want.peak)
          report_mismatch("channel_peak", channel_peak, want.peak);
        if (last !== want.last) report_mismatch("last", last, want.last);
        status_seen[want.status]++;
        if (want.status == ST_OK && (want.code == 16'sd32767 || want.code == -16'sd32767))
          full_scale_codes++;
      end
      results_seen++;
    end
  end

  // Watchdog
  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned      phase;
    logic [CFG_W-1:0] setting;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // scripted opening with moderate idling on both sides
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    for (int row = 0; row < SCRIPT_ROWS; row++) begin
      case (script[row].kind)
        ROW_CFG:   write_num_channels(script[row].smp[CFG_W-1:0]);
        ROW_TYPED: issue(script[row].op, script[row].smp, 1'b1, script[row].want);
        default:   issue(script[row].op, script[row].smp, 1'b0, '0);
      endcase
    end

    // random phases: the first few hit the extremes of the channel setting,
    // including the out-of-range values 0, 17 and 31
    phase = 0;
    while (random_beats < RANDOM_BEATS) begin
      case (phase)
        0:       setting = 5'd16;
        1:       setting = 5'd0;
        2:       setting = 5'd31;
        3:       setting = 5'd17;
        4:       setting = 5'd3;
        default: setting = CFG_W'($urandom_range(0, 31));
      endcase
      write_num_channels(setting);
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 10;
        default: tx_gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_stall_pct = 0;
        1:       rx_stall_pct = 10;
        default: rx_stall_pct = 35;
      endcase
      run_phase($urandom_range(60, 140));
      phase++;
    end

    // Closing pass without idling: empty the store, load a set back to back,
    // refuse a load mid read-out, read it all back, then one fetch too many.
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    while (held_count != 0) issue(OP_FETCH, rand_sample(), 1'b0, '0);
    write_num_channels(CFG_W'($urandom_range(1, 16)));
    repeat (CLOSING_LOADS) issue(OP_LOAD, rand_sample(), 1'b0, '0);
    issue(OP_FETCH, rand_sample(), 1'b0, '0);
    issue(OP_LOAD, rand_sample(), 1'b0, '0);
    while (held_count != 0) issue(OP_FETCH, rand_sample(), 1'b0, '0);
    issue(OP_FETCH, rand_sample(), 1'b0, '0);

    wait_drained();
    repeat (40) @(negedge clk);   // room for any stray late beat
    if (due_results.size() != 0)
      report_mismatch("results never delivered", due_results.size(), 0);

    $display("Covered %0d load and %0d fetch beats over %0d channel settings",
             loads_sent, fetches_sent, $countones(settings_used));
    $display("Results ok/full/empty/busy: %0d/%0d/%0d/%0d, full-scale codes: %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BUSY], full_scale_codes);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/pnq_pkg.sv
rtl/pnq_div.sv
rtl/peak_normalizing_int16_quantizer_core.sv
bench/peak_normalizing_int16_quantizer_core_tb.sv
